// ===== design/pcfc_pkg.sv =====
// package: shared types, constants and helpers of the pixel color format converter
`timescale 1ns / 1ps
package pcfc_pkg;

   localparam int COMP_W      = 16;
   localparam int COUNT_W     = 3;
   localparam int LAYOUT_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = 2 * COMP_W;
   localparam int SUM_W       = PROD_W + 2;

   localparam logic [COMP_W-1:0] LUMA_WR = 16'd19595;
   localparam logic [COMP_W-1:0] LUMA_WG = 16'd38470;
   localparam logic [COMP_W-1:0] LUMA_WB = 16'd7471;

   localparam logic [COMP_W-1:0] FILL_ALPHA_RESET = 16'd255;
   localparam logic [COMP_W-1:0] BYTE_MASK        = 16'h00FF;
   localparam logic [COMP_W-1:0] WORD_MASK        = 16'hFFFF;

   localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_FOUR  = 3'd4;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_RGB        = 3'd0,
      LAYOUT_RGBA       = 3'd1,
      LAYOUT_BGR        = 3'd2,
      LAYOUT_BGRA       = 3'd3,
      LAYOUT_GRAY       = 3'd4,
      LAYOUT_GRAY_ALPHA = 3'd5
   } layout_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_LAYOUT = 2'd0,
      CSR_DEST_LAYOUT   = 2'd1,
      CSR_FILL_ALPHA    = 2'd2,
      CSR_DEST_IS_BYTE  = 2'd3
   } csr_index_type;

   // undefined codes fall back to rgb
   function automatic layout_type fix_layout(input logic [LAYOUT_W-1:0] code);
      layout_type result;
      if (code > 3'd5) begin
         result = LAYOUT_RGB;
      end else begin
         result = layout_type'(code);
      end
      return result;
   endfunction

endpackage

// ===== design/pcfc_channels.sv =====
// interfaces: pixel request and result channels
`timescale 1ns / 1ps
interface pcfc_req_if import pcfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] comp0;
   logic [COMP_W-1:0] comp1;
   logic [COMP_W-1:0] comp2;
   logic [COMP_W-1:0] comp3;

   modport source (output valid, comp0, comp1, comp2, comp3, input ready);
   modport sink   (input valid, comp0, comp1, comp2, comp3, output ready);
endinterface

interface pcfc_rsp_if import pcfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COMP_W-1:0]  out0;
   logic [COMP_W-1:0]  out1;
   logic [COMP_W-1:0]  out2;
   logic [COMP_W-1:0]  out3;
   logic [COUNT_W-1:0] out_count;

   modport source (output valid, out0, out1, out2, out3, out_count, input ready);
   modport sink   (input valid, out0, out1, out2, out3, out_count, output ready);
endinterface

// ===== design/pixel_color_format_converter.sv =====
// top level: pixel color format converter, layout reorder, gray expand, luma, alpha fill
//
// usage
//   req_chan carries one pixel per beat (comp0..comp3 in source layout order),
//   rsp_chan carries one converted pixel per beat (out0..out3, out_count).
//   csr_write_en/csr_index/csr_write_data write the layout, fill alpha and
//   byte mode registers; write them only while no pixel is in flight.
//   a pixel taken into the input register moves on to the decode and luma
//   products register, then to the result register, which offers it on rsp_chan.
//   throughput: one pixel per cycle while rsp_chan.ready stays high; the three
//   register stages each advance whenever the next stage is empty or moving on.
//   when the receiver stalls, the result register holds its beat and the
//   stages behind it fill up; req_chan.ready falls once all three are full.
//   reset (synchronous, active high) empties all stages and sets the
//   registers to rgb in, rgb out, fill alpha 255 and byte mode.
//
`timescale 1ns / 1ps
module pixel_color_format_converter import pcfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   pcfc_req_if.sink               req_chan,
   pcfc_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [LAYOUT_W-1:0] source_layout_ff;
   logic [LAYOUT_W-1:0] dest_layout_ff;
   logic [COMP_W-1:0]   fill_alpha_ff;
   logic                dest_is_byte_ff;

   // stage 1: input register
   logic              s1_valid_ff, s1_valid_in;
   logic [COMP_W-1:0] s1_c0_ff, s1_c1_ff, s1_c2_ff, s1_c3_ff;

   // stage 2: decoded components and luma products
   logic              s2_valid_ff, s2_valid_in;
   logic [COMP_W-1:0] s2_r_ff, s2_g_ff, s2_b_ff, s2_a_ff;
   logic [COMP_W-1:0] s2_r_in, s2_g_in, s2_b_in, s2_a_in;
   logic              s2_gray_ff, s2_gray_in;
   logic [PROD_W-1:0] s2_pr_ff, s2_pg_ff, s2_pb_ff;
   logic [PROD_W-1:0] s2_pr_in, s2_pg_in, s2_pb_in;

   // stage 3: result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COMP_W-1:0]  out0_ff, out1_ff, out2_ff, out3_ff;
   logic [COMP_W-1:0]  out0_in, out1_in, out2_in, out3_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic req_accept;
   logic s2_load;
   logic out_load;

   layout_type        src_layout;
   layout_type        dst_layout;
   logic              src_gray;
   logic              src_alpha;
   logic              src_swap;
   logic [SUM_W-1:0]  luma_sum;
   logic [COMP_W-1:0] luma;
   logic [COMP_W-1:0] mask;

   // handshake and stage advance
   assign out_load   = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || out_load);
   assign req_chan.ready = !s1_valid_ff || s2_load;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         source_layout_ff <= LAYOUT_RGB;
         dest_layout_ff   <= LAYOUT_RGB;
         fill_alpha_ff    <= FILL_ALPHA_RESET;
         dest_is_byte_ff  <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_LAYOUT: source_layout_ff <= csr_write_data[LAYOUT_W-1:0];
            CSR_DEST_LAYOUT:   dest_layout_ff   <= csr_write_data[LAYOUT_W-1:0];
            CSR_FILL_ALPHA:    fill_alpha_ff    <= csr_write_data[COMP_W-1:0];
            CSR_DEST_IS_BYTE:  dest_is_byte_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_c0_ff <= req_chan.comp0;
         s1_c1_ff <= req_chan.comp1;
         s1_c2_ff <= req_chan.comp2;
         s1_c3_ff <= req_chan.comp3;
      end
   end

   // source decode and luma products
   always_comb begin
      src_layout = fix_layout(source_layout_ff);
      src_gray   = (src_layout == LAYOUT_GRAY) || (src_layout == LAYOUT_GRAY_ALPHA);
      src_alpha  = (src_layout == LAYOUT_RGBA) || (src_layout == LAYOUT_BGRA) ||
                   (src_layout == LAYOUT_GRAY_ALPHA);
      src_swap   = (src_layout == LAYOUT_BGR) || (src_layout == LAYOUT_BGRA);

      if (src_gray) begin
         s2_r_in = s1_c0_ff;
         s2_g_in = s1_c0_ff;
         s2_b_in = s1_c0_ff;
      end else if (src_swap) begin
         s2_r_in = s1_c2_ff;
         s2_g_in = s1_c1_ff;
         s2_b_in = s1_c0_ff;
      end else begin
         s2_r_in = s1_c0_ff;
         s2_g_in = s1_c1_ff;
         s2_b_in = s1_c2_ff;
      end

      if (!src_alpha) begin
         s2_a_in = fill_alpha_ff;
      end else if (src_gray) begin
         s2_a_in = s1_c1_ff;
      end else begin
         s2_a_in = s1_c3_ff;
      end

      s2_gray_in = src_gray;
      s2_pr_in   = {{COMP_W{1'b0}}, s2_r_in} * {{COMP_W{1'b0}}, LUMA_WR};
      s2_pg_in   = {{COMP_W{1'b0}}, s2_g_in} * {{COMP_W{1'b0}}, LUMA_WG};
      s2_pb_in   = {{COMP_W{1'b0}}, s2_b_in} * {{COMP_W{1'b0}}, LUMA_WB};
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_r_ff    <= s2_r_in;
         s2_g_ff    <= s2_g_in;
         s2_b_ff    <= s2_b_in;
         s2_a_ff    <= s2_a_in;
         s2_gray_ff <= s2_gray_in;
         s2_pr_ff   <= s2_pr_in;
         s2_pg_ff   <= s2_pg_in;
         s2_pb_ff   <= s2_pb_in;
      end
   end

   // luma sum, destination select and narrowing
   always_comb begin
      luma_sum = SUM_W'(s2_pr_ff) + SUM_W'(s2_pg_ff) + SUM_W'(s2_pb_ff);
      luma     = s2_gray_ff ? s2_r_ff : luma_sum[PROD_W-1:COMP_W];
      mask     = dest_is_byte_ff ? BYTE_MASK : WORD_MASK;
      dst_layout = fix_layout(dest_layout_ff);

      out0_in      = '0;
      out1_in      = '0;
      out2_in      = '0;
      out3_in      = '0;
      out_count_in = COUNT_THREE;
      case (dst_layout)
         LAYOUT_RGB: begin
            out0_in = s2_r_ff;
            out1_in = s2_g_ff;
            out2_in = s2_b_ff;
            out_count_in = COUNT_THREE;
         end
         LAYOUT_RGBA: begin
            out0_in = s2_r_ff;
            out1_in = s2_g_ff;
            out2_in = s2_b_ff;
            out3_in = s2_a_ff;
            out_count_in = COUNT_FOUR;
         end
         LAYOUT_BGR: begin
            out0_in = s2_b_ff;
            out1_in = s2_g_ff;
            out2_in = s2_r_ff;
            out_count_in = COUNT_THREE;
         end
         LAYOUT_BGRA: begin
            out0_in = s2_b_ff;
            out1_in = s2_g_ff;
            out2_in = s2_r_ff;
            out3_in = s2_a_ff;
            out_count_in = COUNT_FOUR;
         end
         LAYOUT_GRAY: begin
            out0_in = luma;
            out_count_in = COUNT_ONE;
         end
         default: begin
            out0_in = luma;
            out1_in = s2_a_ff;
            out_count_in = COUNT_TWO;
         end
      endcase

      out0_in = out0_in & mask;
      out1_in = out1_in & mask;
      out2_in = out2_in & mask;
      out3_in = out3_in & mask;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out0_ff      <= out0_in;
         out1_ff      <= out1_in;
         out2_ff      <= out2_in;
         out3_ff      <= out3_in;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out0      = out0_ff;
   assign rsp_chan.out1      = out1_ff;
   assign rsp_chan.out2      = out2_ff;
   assign rsp_chan.out3      = out3_ff;
   assign rsp_chan.out_count = out_count_ff;

`ifndef SYNTHESIS
   // with a count of one, the components beyond the count are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.out_count == COUNT_ONE) |->
         (rsp_chan.out1 == '0) && (rsp_chan.out2 == '0) && (rsp_chan.out3 == '0))
      else $error("unused components not cleared");

   // byte mode leaves no high bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && dest_is_byte_ff |->
         (rsp_chan.out0[COMP_W-1:8] == '0) && (rsp_chan.out1[COMP_W-1:8] == '0) &&
         (rsp_chan.out2[COMP_W-1:8] == '0) && (rsp_chan.out3[COMP_W-1:8] == '0))
      else $error("byte mode result has high bits set");

   // an accepted beat lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted beat lost");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== tb/tb.sv =====
// testbench: pixel color format converter checked beat by beat against a behavioral predictor
`timescale 1ns / 1ps
module tb;
   import pcfc_pkg::*;

   typedef struct packed {
      logic [15:0] comp0;
      logic [15:0] comp1;
      logic [15:0] comp2;
      logic [15:0] comp3;
   } pixel_in_t;

   typedef struct packed {
      logic [15:0] out0;
      logic [15:0] out1;
      logic [15:0] out2;
      logic [15:0] out3;
      logic [2:0]  out_count;
   } pixel_out_t;

   localparam logic [33:0] LUMA_RED_Q16   = 34'd19595;
   localparam logic [33:0] LUMA_GREEN_Q16 = 34'd38470;
   localparam logic [33:0] LUMA_BLUE_Q16  = 34'd7471;
   localparam logic [2:0]  LAYOUT_CODE_SIX   = 3'd6;
   localparam logic [2:0]  LAYOUT_CODE_SEVEN = 3'd7;
   localparam int          LONG_STALL_CYCLES = 300;
   localparam int          PIXELS_PER_SETTING = 25;
   localparam int          MAX_PRINTED = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   pcfc_req_if req_chan ();
   pcfc_rsp_if rsp_chan ();

   pixel_color_format_converter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // mirror of the block's registers
   logic [2:0]  source_layout_reg = LAYOUT_RGB;
   logic [2:0]  dest_layout_reg   = LAYOUT_RGB;
   logic [15:0] fill_alpha_reg    = 16'd255;
   logic        byte_mode_reg     = 1'b1;

   pixel_in_t  queued_pixels[$];
   pixel_out_t pending_conversions[$];
   pixel_in_t  offered_pixel;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic sender_hold  = 1'b0;
   int long_stall_req = 0;
   int long_stall_seen;
   int stall_left;

   int accepted_pixels = 0;
   int checked_pixels  = 0;
   int mismatch_count  = 0;
   int setting_count   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic pixel_out_t convert_pixel(pixel_in_t pix);
      layout_type  src;
      layout_type  dst;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic [15:0] luma;
      logic [15:0] mask;
      logic [33:0] luma_acc;
      logic        src_has_alpha;
      pixel_out_t  res;
      src = (source_layout_reg > LAYOUT_GRAY_ALPHA) ? LAYOUT_RGB : layout_type'(source_layout_reg);
      dst = (dest_layout_reg > LAYOUT_GRAY_ALPHA) ? LAYOUT_RGB : layout_type'(dest_layout_reg);
      src_has_alpha = (src == LAYOUT_RGBA) || (src == LAYOUT_BGRA) || (src == LAYOUT_GRAY_ALPHA);
      alpha = fill_alpha_reg;
      if (src == LAYOUT_GRAY || src == LAYOUT_GRAY_ALPHA) begin
         red = pix.comp0;
         green = pix.comp0;
         blue = pix.comp0;
         luma = pix.comp0;
         if (src_has_alpha) alpha = pix.comp1;
      end else begin
         if (src == LAYOUT_BGR || src == LAYOUT_BGRA) begin
            red = pix.comp2;
            blue = pix.comp0;
         end else begin
            red = pix.comp0;
            blue = pix.comp2;
         end
         green = pix.comp1;
         if (src_has_alpha) alpha = pix.comp3;
         luma_acc = 34'(red) * LUMA_RED_Q16 + 34'(green) * LUMA_GREEN_Q16
                  + 34'(blue) * LUMA_BLUE_Q16;
         luma = luma_acc[31:16];
      end
      res = '0;
      case (dst)
         LAYOUT_RGB: begin
            res.out0 = red; res.out1 = green; res.out2 = blue; res.out_count = 3'd3;
         end
         LAYOUT_RGBA: begin
            res.out0 = red; res.out1 = green; res.out2 = blue; res.out3 = alpha;
            res.out_count = 3'd4;
         end
         LAYOUT_BGR: begin
            res.out0 = blue; res.out1 = green; res.out2 = red; res.out_count = 3'd3;
         end
         LAYOUT_BGRA: begin
            res.out0 = blue; res.out1 = green; res.out2 = red; res.out3 = alpha;
            res.out_count = 3'd4;
         end
         LAYOUT_GRAY: begin
            res.out0 = luma; res.out_count = 3'd1;
         end
         default: begin
            res.out0 = luma; res.out1 = alpha; res.out_count = 3'd2;
         end
      endcase
      mask = byte_mode_reg ? 16'h00FF : 16'hFFFF;
      res.out0 &= mask;
      res.out1 &= mask;
      res.out2 &= mask;
      res.out3 &= mask;
      return res;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("tb: pixel %0d %s got %h want %h", checked_pixels, field, got, want);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_SOURCE_LAYOUT: source_layout_reg = data[2:0];
         CSR_DEST_LAYOUT:   dest_layout_reg = data[2:0];
         CSR_FILL_ALPHA:    fill_alpha_reg = data;
         CSR_DEST_IS_BYTE:  byte_mode_reg = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(logic [2:0] src, logic [2:0] dst, logic [15:0] fill,
                            logic byte_mode);
      write_reg(CSR_SOURCE_LAYOUT, {13'($urandom), src});
      write_reg(CSR_DEST_LAYOUT, {13'($urandom), dst});
      write_reg(CSR_FILL_ALPHA, fill);
      write_reg(CSR_DEST_IS_BYTE, {15'($urandom), byte_mode});
      setting_count++;
      @(negedge clock);
   endtask

   task automatic push_pixel(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                             logic [15:0] c3);
      pixel_in_t pix;
      pix.comp0 = c0;
      pix.comp1 = c1;
      pix.comp2 = c2;
      pix.comp3 = c3;
      queued_pixels.push_back(pix);
   endtask

   function automatic logic [15:0] random_comp();
      logic [15:0] val;
      case ($urandom_range(7))
         0: val = 16'h0000;
         1: val = 16'hFFFF;
         2: val = 16'h00FF;
         3: val = 16'hFF00;
         default: val = 16'($urandom);
      endcase
      return val;
   endfunction

   task automatic push_random_pixels(int count);
      repeat (count) push_pixel(random_comp(), random_comp(), random_comp(), random_comp());
   endtask

   task automatic drain();
      while (queued_pixels.size() != 0 || req_chan.valid || pending_conversions.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pending_conversions.push_back(convert_pixel(offered_pixel));
            accepted_pixels++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_pixels.size() != 0 && !sender_hold
                && $urandom_range(99) >= send_idle_pct) begin
               offered_pixel = queued_pixels.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.comp0 <= offered_pixel.comp0;
               req_chan.comp1 <= offered_pixel.comp1;
               req_chan.comp2 <= offered_pixel.comp2;
               req_chan.comp3 <= offered_pixel.comp3;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver, with long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
         long_stall_seen <= 0;
      end else if (long_stall_seen != long_stall_req) begin
         long_stall_seen <= long_stall_req;
         stall_left <= LONG_STALL_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      pixel_out_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_conversions.size() == 0) begin
            report_mismatch("unexpected beat, out0", rsp_chan.out0, 0);
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_chan.out0 !== want.out0) report_mismatch("out0", rsp_chan.out0, want.out0);
            if (rsp_chan.out1 !== want.out1) report_mismatch("out1", rsp_chan.out1, want.out1);
            if (rsp_chan.out2 !== want.out2) report_mismatch("out2", rsp_chan.out2, want.out2);
            if (rsp_chan.out3 !== want.out3) report_mismatch("out3", rsp_chan.out3, want.out3);
            if (rsp_chan.out_count !== want.out_count)
               report_mismatch("out_count", rsp_chan.out_count, want.out_count);
         end
         checked_pixels++;
      end
   end

   initial begin
      #1_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int setting;
      csr_write_en = 1'b0;
      csr_index = CSR_SOURCE_LAYOUT;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings first, then directed corners
      push_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      push_pixel(16'hFFFF, 16'h0000, 16'h00FF, 16'hFFFF);
      drain();

      configure(LAYOUT_RGB, LAYOUT_GRAY, 16'h0000, 1'b0);
      push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      push_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
      push_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      push_pixel(16'h0001, 16'h0001, 16'h0001, 16'hAAAA);
      drain();

      configure(LAYOUT_BGRA, LAYOUT_RGBA, 16'hFFFF, 1'b0);
      push_pixel(16'h1111, 16'h2222, 16'h3333, 16'hFFFF);
      push_pixel(16'hA5A5, 16'h5A5A, 16'h8000, 16'h0000);
      drain();

      configure(LAYOUT_GRAY_ALPHA, LAYOUT_BGRA, 16'h0000, 1'b1);
      push_pixel(16'h1234, 16'hABCD, 16'hFFFF, 16'hFFFF);
      push_pixel(16'hFF80, 16'h0001, 16'h0000, 16'h0000);
      drain();

      configure(LAYOUT_RGB, LAYOUT_GRAY_ALPHA, 16'h01FF, 1'b1);
      push_pixel(16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555);
      push_pixel(16'h0100, 16'h0200, 16'h0300, 16'h0000);
      drain();

      configure(LAYOUT_CODE_SEVEN, LAYOUT_CODE_SIX, 16'h7777, 1'b0);
      push_pixel(16'hCAFE, 16'hBEEF, 16'h0F0F, 16'hF0F0);
      push_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      drain();

      configure(LAYOUT_GRAY, LAYOUT_RGBA, 16'hFFFF, 1'b1);
      push_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      push_pixel(16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();

      // every source and destination code, undefined ones too
      for (setting = 0; setting < 64; setting++) begin
         configure(3'(setting / 8), 3'(setting % 8),
                   (setting % 5 == 0) ? 16'h0000 :
                   (setting % 5 == 1) ? 16'hFFFF : 16'($urandom),
                   1'($urandom));
         set_idling(setting % 4);
         if (setting == 9) begin
            set_idling(0);
            long_stall_req++;
            push_random_pixels(2 * PIXELS_PER_SETTING);
         end else if (setting == 22) begin
            push_random_pixels(PIXELS_PER_SETTING / 2);
            while (queued_pixels.size() != 0) @(negedge clock);
            sender_hold = 1'b1;
            while (req_chan.valid || pending_conversions.size() != 0) @(negedge clock);
            sender_hold = 1'b0;
            push_random_pixels(PIXELS_PER_SETTING / 2);
         end else begin
            push_random_pixels(PIXELS_PER_SETTING);
         end
         drain();
      end

      repeat (10) @(negedge clock);
      if (pending_conversions.size() != 0)
         report_mismatch("results missing, count", pending_conversions.size(), 0);
      $display("tb: %0d pixels sent, %0d results checked over %0d register settings",
               accepted_pixels, checked_pixels, setting_count);
      $display("tb: %0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
